>>> rtl/stki_pkg.sv
`default_nettype none
package stki_pkg;

  localparam int unsigned DepthDef  = 16;
  localparam int unsigned ScoreW    = 32;
  localparam int unsigned TagW      = 16;
  localparam int unsigned RankW     = 4;
  localparam int unsigned HeldW     = 5;
  localparam int unsigned CapW      = 5;
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [TagW-1:0]   tag;
  } entry_t;

  // offered item broadcast to every cell
  typedef struct packed {
    entry_t item;
    logic   upd;
  } offer_t;

endpackage
`default_nettype wire

>>> rtl/stki_offer_if.sv
`default_nettype none
interface stki_offer_if;
  logic                          valid;
  logic                          ready;
  logic [stki_pkg::ScoreW-1:0]   new_score;
  logic [stki_pkg::TagW-1:0]     new_tag;

  modport source (output valid, output new_score, output new_tag, input ready);
  modport sink   (input valid, input new_score, input new_tag, output ready);
endinterface
`default_nettype wire

>>> rtl/stki_result_if.sv
`default_nettype none
interface stki_result_if;
  logic                         valid;
  logic                         ready;
  logic                         placed;
  logic [stki_pkg::RankW-1:0]   rank;
  logic [stki_pkg::HeldW-1:0]   entries_held;

  modport source (output valid, output placed, output rank, output entries_held, input ready);
  modport sink   (input valid, input placed, input rank, input entries_held, output ready);
endinterface
`default_nettype wire

>>> rtl/sorted_top_k_insert_top.sv
// Sorted top-k table: holds up to capacity entries (32-bit score, 16-bit tag)
// in descending score order, ties kept in arrival order. Each offered item is
// compared against every held entry at once by a row of DEPTH cells; on
// insertion each cell below the insertion point takes its left neighbor's
// entry in the same cycle, and the last one drops out when the table is full.
// One item is accepted per clock; its result (placed, rank, entries_held)
// appears in the output register on the following cycle, and the input is
// held off only while that result is waiting to be taken. Offers whose place
// falls at or past capacity, or that arrive while capacity is zero or below
// the entry count, are rejected with rank 0. Capacity above DEPTH acts as
// DEPTH. Write capacity only while no item is in flight.
`default_nettype none
module sorted_top_k_insert_top #(
  parameter int unsigned DEPTH = stki_pkg::DepthDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [stki_pkg::CapW-1:0] cfg_wdata_i,
  stki_offer_if.sink                     offer_i,
  stki_result_if.source                  result_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [stki_pkg::CapW-1:0] cap_q;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [CW-1:0]             cap_eff;
  logic [CW-1:0]             pos;
  logic                      accept, placed;

  logic                      out_valid_q;
  logic                      out_placed_q;
  logic [stki_pkg::RankW-1:0] out_rank_q;
  logic [stki_pkg::HeldW-1:0] out_held_q;

  stki_pkg::offer_t          offer;
  logic [DEPTH:0]            ge_chain;
  logic [DEPTH-1:0]          here;
  stki_pkg::entry_t          entry_chain [DEPTH+1];

  assign offer_i.ready = !out_valid_q || result_o.ready;
  assign accept        = offer_i.valid && offer_i.ready;

  assign cap_eff = (32'(cap_q) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(cap_q);

  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos |= here[i] ? CW'(i) : '0;
    end
    if (!(|here)) begin
      pos = CW'(DEPTH);
    end
  end

  assign placed = (cap_eff != '0) && (cnt_q <= cap_eff) && (pos < cap_eff);
  assign cnt_d  = (cnt_q < cap_eff) ? cnt_q + CW'(1) : cnt_q;

  assign offer.item.score = offer_i.new_score;
  assign offer.item.tag   = offer_i.new_tag;
  assign offer.upd        = accept && placed;

  // cell 0 sees the offered entry as its left neighbor
  assign ge_chain[0]    = 1'b1;
  assign entry_chain[0] = offer.item;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    stki_cell u_cell (
      .clk_i        (clk_i),
      .cell_valid_i (CW'(i) < cnt_q),
      .offer_i      (offer),
      .left_ge_i    (ge_chain[i]),
      .left_entry_i (entry_chain[i]),
      .ge_o         (ge_chain[i+1]),
      .here_o       (here[i]),
      .entry_o      (entry_chain[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= stki_pkg::CapReset;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
        if (placed) begin
          cnt_q <= cnt_d;
        end
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_placed_q <= placed;
      out_rank_q   <= placed ? stki_pkg::RankW'(pos) : '0;
      out_held_q   <= placed ? stki_pkg::HeldW'(cnt_d) : stki_pkg::HeldW'(cnt_q);
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.placed       = out_placed_q;
  assign result_o.rank         = out_rank_q;
  assign result_o.entries_held = out_held_q;

endmodule
`default_nettype wire

>>> rtl/stki_cell.sv
`default_nettype none
module stki_cell (
  input  wire logic             clk_i,
  input  wire logic             cell_valid_i,
  input  wire stki_pkg::offer_t offer_i,
  input  wire logic             left_ge_i,
  input  wire stki_pkg::entry_t left_entry_i,
  output logic                  ge_o,
  output logic                  here_o,
  output stki_pkg::entry_t      entry_o
);

  stki_pkg::entry_t entry_q, entry_d;

  // held entry ranks at or above the offered one
  assign ge_o    = cell_valid_i && (entry_q.score >= offer_i.item.score);
  assign here_o  = !ge_o && left_ge_i;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (offer_i.upd && !ge_o) begin
      if (left_ge_i) begin
        entry_d = offer_i.item;
      end else begin
        entry_d = left_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

>>> rtl/stki_chk.sv
`default_nettype none
module stki_chk (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_ready_i,
  input  wire logic                        placed_i,
  input  wire logic [stki_pkg::RankW-1:0]  rank_i,
  input  wire logic [stki_pkg::HeldW-1:0]  held_i
);

  logic out_acc;
  assign out_acc = out_valid_i && out_ready_i;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_reject_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !placed_i |-> rank_i == '0)
    else $error("rejected item with nonzero rank");

  a_rank_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && placed_i |-> rank_i < held_i || held_i == '0)
    else $error("rank outside held entries");

  a_held_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && $past(out_acc) && $past(rst_ni) |->
      held_i >= $past(held_i) && held_i <= $past(held_i) + 5'd1)
    else $error("entry count jumped between items");

endmodule

bind sorted_top_k_insert_top stki_chk u_stki_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .placed_i    (result_o.placed),
  .rank_i      (result_o.rank),
  .held_i      (result_o.entries_held)
);
`default_nettype wire
